// ----- src/weighted_variable_bin_histogram_top_macros.svh -----
// Assertion macros used by the histogram top module.
`ifndef WEIGHTED_VARIABLE_BIN_HISTOGRAM_TOP_MACROS_SVH
`define WEIGHTED_VARIABLE_BIN_HISTOGRAM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WHB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("whb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WHB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("whb: next-cycle check failed");

`endif

// ----- src/whb_pkg.sv -----
package whb_pkg;

  localparam int MAX_BINS = 64;
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int IDX_W    = $clog2(MAX_BINS + 2);
  localparam int VAL_W    = 32;
  localparam int WGT_W    = 32;
  localparam int SUM_W    = 48;
  localparam int SQ_W     = 64;
  localparam int NE_W     = 7;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [IDX_W-1:0] FOUND_UNDER = IDX_W'(MAX_BINS);
  localparam logic [IDX_W-1:0] FOUND_OVER  = IDX_W'(MAX_BINS + 1);
  localparam logic [NE_W-1:0]  NE_RESET    = NE_W'(MAX_BINS + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef struct packed {
    logic                     valid;
    action_e                  action;
    logic [IDX_W-1:0]         idx;
    logic [VAL_W-1:0]         value;
    logic                     hit;
    logic [BIN_W-1:0]         cand;
    logic signed [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]          sq;
    logic                     under;
    logic                     over;
  } whb_token_t;

  typedef struct packed {
    logic                     clr;
    logic                     edge_we;
    logic [BIN_W-1:0]         edge_idx;
    logic [VAL_W-1:0]         edge_val;
    logic                     upd_we;
    logic [BIN_W-1:0]         upd_idx;
    logic signed [SUM_W-1:0]  upd_sum;
    logic [SQ_W-1:0]          upd_sq;
  } whb_ctl_t;

endpackage

// ----- src/whb_if.sv -----
interface whb_in_if;
  import whb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [IDX_W-1:0]        index;
  logic [VAL_W-1:0]        value;
  logic signed [WGT_W-1:0] weight;

  modport source (output valid, action, index, value, weight, input ready);
  modport sink   (input valid, action, index, value, weight, output ready);
endinterface

interface whb_out_if;
  import whb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        found_bin;
  logic signed [SUM_W-1:0] bin_sum;
  logic [SQ_W-1:0]         bin_sum_squares;
  logic signed [SUM_W-1:0] underflow_sum;
  logic signed [SUM_W-1:0] overflow_sum;
  logic                    saturated;

  modport source (output valid, found_bin, bin_sum, bin_sum_squares, underflow_sum,
                  overflow_sum, saturated, input ready);
  modport sink   (input valid, found_bin, bin_sum, bin_sum_squares, underflow_sum,
                  overflow_sum, saturated, output ready);
endinterface

// ----- src/weighted_variable_bin_histogram_top.sv -----
// Channel   Dir  Fields
// in_i      in   action, index, value, weight
// out_o     out  found_bin, bin_sum, bin_sum_squares, underflow_sum, overflow_sum, saturated
// APB       in   num_edges at byte address 0
//
// Every item walks a row of MAX_BINS cells, one cell per cycle, then waits in a done register
// until the output register is free and is written there as its result beat; one item is in flight.
// Reset zeroes all sums and sets num_edges to 65; the edges hold no value until written.
// A result waits in the output register while the next item is accepted and walks the row.
// A finished item that finds the output register still full waits until it is taken.
`include "weighted_variable_bin_histogram_top_macros.svh"

module weighted_variable_bin_histogram_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  whb_in_if.sink                      in_i,
  whb_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [whb_pkg::CFG_AW-1:0]  paddr,
  input  logic [whb_pkg::CFG_DW-1:0]  pwdata,
  output logic [whb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import whb_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  function automatic logic [SUM_W:0] add_sat(input logic signed [SUM_W-1:0] acc,
                                             input logic signed [WGT_W-1:0] w);
    logic [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + {{(SUM_W+1-WGT_W){w[WGT_W-1]}}, w};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, SUM_MIN} : {1'b1, SUM_MAX};
    end
    return {1'b0, s[SUM_W-1:0]};
  endfunction

  function automatic logic [SQ_W:0] add_sq(input logic [SQ_W-1:0] acc,
                                           input logic [SQ_W-1:0] sq);
    logic [SQ_W:0] t;
    t = {1'b0, acc} + {1'b0, sq};
    if (t[SQ_W]) begin
      return {1'b1, {SQ_W{1'b1}}};
    end
    return {1'b0, t[SQ_W-1:0]};
  endfunction

  logic [IDX_W-1:0]        n_last;
  whb_token_t              chain_tok [MAX_BINS+1];
  whb_ctl_t                ctl;

  logic                    busy_q;
  logic signed [WGT_W-1:0] weight_q;
  logic [SQ_W-1:0]         sqw_q;
  logic [VAL_W-1:0]        bound_last_q;
  whb_token_t              done_q;
  logic                    done_valid_q;
  logic signed [SUM_W-1:0] below_q, below_d;
  logic signed [SUM_W-1:0] above_q, above_d;

  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_found_q, fin_found;
  logic signed [SUM_W-1:0] out_sum_q, fin_sum;
  logic [SQ_W-1:0]         out_sq_q, fin_sq;
  logic                    out_sat_q, fin_sat;

  logic                    in_fire;
  logic                    finalize;
  action_e                 act_in;
  logic signed [WGT_W-1:0] w_in;
  logic signed [SQ_W-1:0]  sq_in;
  logic                    over_f;
  logic [SUM_W:0]          add_below, add_above, add_bin;
  logic [SQ_W:0]           add_sqr;

  whb_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .n_last_o (n_last)
  );

  assign act_in   = action_e'(in_i.action);
  assign w_in     = in_i.weight;
  assign sq_in    = w_in * w_in;
  assign in_i.ready = !busy_q;
  assign in_fire  = in_i.valid && in_i.ready;
  assign finalize = done_valid_q && (!out_valid_q || out_o.ready);

  always_comb begin
    chain_tok[0]        = '0;
    chain_tok[0].valid  = in_fire;
    chain_tok[0].action = act_in;
    chain_tok[0].idx    = in_i.index;
    chain_tok[0].value  = in_i.value;
  end

  for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
    whb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (BIN_W'(k)),
      .n_last_i   (n_last),
      .ctl_i      (ctl),
      .tok_i      (chain_tok[k]),
      .tok_o      (chain_tok[k+1])
    );
  end

  assign over_f    = done_q.over ||
                     ((n_last == IDX_W'(MAX_BINS)) && (done_q.value >= bound_last_q));
  assign add_below = add_sat(below_q, weight_q);
  assign add_above = add_sat(above_q, weight_q);
  assign add_bin   = add_sat(done_q.sum, weight_q);
  assign add_sqr   = add_sq(done_q.sq, sqw_q);

  always_comb begin
    below_d      = below_q;
    above_d      = above_q;
    fin_found    = '0;
    fin_sum      = '0;
    fin_sq       = '0;
    fin_sat      = 1'b0;
    ctl          = '0;
    ctl.clr      = finalize && (done_q.action == ACT_CLEAR);
    ctl.edge_we  = in_fire && (act_in == ACT_WRITE) && (in_i.index < IDX_W'(MAX_BINS));
    ctl.edge_idx = in_i.index[BIN_W-1:0];
    ctl.edge_val = in_i.value;
    ctl.upd_idx  = done_q.cand;
    ctl.upd_sum  = add_bin[SUM_W-1:0];
    ctl.upd_sq   = add_sqr[SQ_W-1:0];
    if (ctl.clr) begin
      below_d = '0;
      above_d = '0;
    end
    if (finalize) begin
      case (done_q.action)
        ACT_FILL: begin
          if (done_q.under) begin
            fin_found = FOUND_UNDER;
            below_d   = add_below[SUM_W-1:0];
            fin_sat   = add_below[SUM_W];
          end else if (over_f) begin
            fin_found = FOUND_OVER;
            above_d   = add_above[SUM_W-1:0];
            fin_sat   = add_above[SUM_W];
          end else begin
            fin_found  = {1'b0, done_q.cand};
            ctl.upd_we = 1'b1;
            fin_sat    = add_bin[SUM_W] || add_sqr[SQ_W];
          end
        end
        ACT_READ: begin
          if (done_q.hit) begin
            fin_sum = done_q.sum;
            fin_sq  = done_q.sq;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      done_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      below_q      <= '0;
      above_q      <= '0;
    end else begin
      below_q <= below_d;
      above_q <= above_d;
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (finalize) begin
        busy_q <= 1'b0;
      end
      if (chain_tok[MAX_BINS].valid) begin
        done_valid_q <= 1'b1;
      end else if (finalize) begin
        done_valid_q <= 1'b0;
      end
      if (finalize) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      weight_q <= w_in;
      sqw_q    <= SQ_W'(sq_in);
      if ((act_in == ACT_WRITE) && (in_i.index == IDX_W'(MAX_BINS))) begin
        bound_last_q <= in_i.value;
      end
    end
    if (chain_tok[MAX_BINS].valid) begin
      done_q <= chain_tok[MAX_BINS];
    end
    if (finalize) begin
      out_found_q <= fin_found;
      out_sum_q   <= fin_sum;
      out_sq_q    <= fin_sq;
      out_sat_q   <= fin_sat;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.found_bin       = out_found_q;
  assign out_o.bin_sum         = out_sum_q;
  assign out_o.bin_sum_squares = out_sq_q;
  assign out_o.underflow_sum   = below_q;
  assign out_o.overflow_sum    = above_q;
  assign out_o.saturated       = out_sat_q;

  `WHB_ASSERT_NEXT(a_busy_after_accept, in_fire, busy_q && !in_i.ready)
  `WHB_ASSERT_IMPL(a_exit_slot_free, chain_tok[MAX_BINS].valid, busy_q && !done_valid_q)
  `WHB_ASSERT_IMPL(a_final_in_flight, finalize, busy_q && !chain_tok[MAX_BINS].valid)

endmodule

// ----- src/whb_cfg.sv -----
module whb_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [whb_pkg::CFG_AW-1:0]  paddr,
  input  logic [whb_pkg::CFG_DW-1:0]  pwdata,
  output logic [whb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [whb_pkg::IDX_W-1:0]   n_last_o
);
  import whb_pkg::*;

  localparam logic REG_NUM_EDGES = 1'b0;

  logic [NE_W-1:0] num_edges_q, num_edges_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    num_edges_d = num_edges_q;
    if (wr_en && (paddr[CFG_AW-1] == REG_NUM_EDGES)) begin
      num_edges_d = pwdata[NE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_edges_q <= NE_RESET;
    end else begin
      num_edges_q <= num_edges_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_AW-1] == REG_NUM_EDGES) begin
      prdata = CFG_DW'(num_edges_q);
    end
  end

  always_comb begin
    if (num_edges_q < NE_W'(2)) begin
      n_last_o = IDX_W'(1);
    end else if (num_edges_q > NE_W'(MAX_BINS + 1)) begin
      n_last_o = IDX_W'(MAX_BINS);
    end else begin
      n_last_o = IDX_W'(num_edges_q - NE_W'(1));
    end
  end

endmodule

// ----- src/whb_cell.sv -----
module whb_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [whb_pkg::BIN_W-1:0]   cell_idx_i,
  input  logic [whb_pkg::IDX_W-1:0]   n_last_i,
  input  whb_pkg::whb_ctl_t           ctl_i,
  input  whb_pkg::whb_token_t         tok_i,
  output whb_pkg::whb_token_t         tok_o
);
  import whb_pkg::*;

  logic [VAL_W-1:0]        bound_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sq_q;
  whb_token_t              tok_q, tok_d;
  logic [IDX_W-1:0]        my_idx;

  assign my_idx = {1'b0, cell_idx_i};

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid) begin
      case (tok_i.action)
        ACT_FILL: begin
          if (cell_idx_i == '0) begin
            tok_d.under = tok_i.value < bound_q;
          end
          if ((my_idx < n_last_i) && (bound_q <= tok_i.value)) begin
            tok_d.hit  = 1'b1;
            tok_d.cand = cell_idx_i;
            tok_d.sum  = sum_q;
            tok_d.sq   = sq_q;
          end
          if (my_idx == n_last_i) begin
            tok_d.over = tok_i.value >= bound_q;
          end
        end
        ACT_READ: begin
          if (tok_i.idx == my_idx) begin
            tok_d.hit = 1'b1;
            tok_d.sum = sum_q;
            tok_d.sq  = sq_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (ctl_i.clr) begin
        sum_q <= '0;
        sq_q  <= '0;
      end else if (ctl_i.upd_we && (ctl_i.upd_idx == cell_idx_i)) begin
        sum_q <= ctl_i.upd_sum;
        sq_q  <= ctl_i.upd_sq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.edge_we && (ctl_i.edge_idx == cell_idx_i)) begin
      bound_q <= ctl_i.edge_val;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- dv/whb_result_compare.sv -----
module whb_result_compare
  import whb_pkg::*;
#(
  parameter logic [CFG_AW-1:0] NUM_EDGES_ADDR = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  whb_in_if                 in_mon,
  whb_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                mismatch_count_o,
  output int                pending_count_o
);

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic [IDX_W-1:0]        found_bin;
    logic signed [SUM_W-1:0] bin_sum;
    logic [SQ_W-1:0]         bin_sum_squares;
    logic signed [SUM_W-1:0] underflow_sum;
    logic signed [SUM_W-1:0] overflow_sum;
    logic                    saturated;
  } hist_result_t;

  logic [VAL_W-1:0] edge_q [0:MAX_BINS];
  longint           bin_total [MAX_BINS];
  logic [SQ_W-1:0]  bin_square_total [MAX_BINS];
  longint           below_total;
  longint           above_total;
  logic [NE_W-1:0]  edges_cfg;
  hist_result_t     expected_q [$];
  int               mismatches;

  assign mismatch_count_o = mismatches;

  function automatic longint add_clipped(longint acc, longint w, inout bit clipped);
    longint s;
    s = acc + w;
    if (s > SUM_HI) begin
      clipped = 1'b1;
      return SUM_HI;
    end
    if (s < SUM_LO) begin
      clipped = 1'b1;
      return SUM_LO;
    end
    return s;
  endfunction

  function automatic int edges_active();
    if (edges_cfg < 2) return 2;
    if (edges_cfg > MAX_BINS + 1) return MAX_BINS + 1;
    return int'(edges_cfg);
  endfunction

  // The highest-numbered edge at or below the energy wins, so unordered tables stay defined.
  function automatic logic [IDX_W-1:0] find_bin(logic [VAL_W-1:0] v);
    int n;
    int hit;
    n = edges_active();
    hit = 0;
    if (v < edge_q[0]) return FOUND_UNDER;
    if (v >= edge_q[n-1]) return FOUND_OVER;
    for (int i = 0; i < n - 1; i++) begin
      if (edge_q[i] <= v) hit = i;
    end
    return IDX_W'(hit);
  endfunction

  function automatic hist_result_t apply_item(action_e act, logic [IDX_W-1:0] idx,
                                              logic [VAL_W-1:0] v,
                                              logic signed [WGT_W-1:0] w);
    hist_result_t r;
    longint wt;
    bit clip;
    logic [SQ_W-1:0] sq;
    logic [SQ_W-1:0] total;
    int b;
    r = '0;
    wt = longint'(w);
    clip = 1'b0;
    case (act)
      ACT_CLEAR: begin
        for (int i = 0; i < MAX_BINS; i++) begin
          bin_total[i] = 0;
          bin_square_total[i] = '0;
        end
        below_total = 0;
        above_total = 0;
      end
      ACT_WRITE: begin
        if (idx <= MAX_BINS) edge_q[idx] = v;
      end
      ACT_FILL: begin
        r.found_bin = find_bin(v);
        if (r.found_bin == FOUND_UNDER) begin
          below_total = add_clipped(below_total, wt, clip);
        end else if (r.found_bin == FOUND_OVER) begin
          above_total = add_clipped(above_total, wt, clip);
        end else begin
          b = int'(r.found_bin);
          sq = SQ_W'(wt * wt);
          total = bin_square_total[b] + sq;
          bin_total[b] = add_clipped(bin_total[b], wt, clip);
          if (total < sq) begin
            total = '1;
            clip = 1'b1;
          end
          bin_square_total[b] = total;
        end
      end
      default: begin
        if (idx < MAX_BINS) begin
          r.bin_sum = SUM_W'(bin_total[idx]);
          r.bin_sum_squares = bin_square_total[idx];
        end
      end
    endcase
    r.underflow_sum = SUM_W'(below_total);
    r.overflow_sum = SUM_W'(above_total);
    r.saturated = clip;
    return r;
  endfunction

  function automatic int field_differs(string name, logic [SQ_W-1:0] want_v,
                                       logic [SQ_W-1:0] got_v);
    if (got_v === want_v) return 0;
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    hist_result_t want;
    hist_result_t got;
    int bad;
    if (!rst_ni) begin
      for (int i = 0; i <= MAX_BINS; i++) edge_q[i] = '0;
      for (int i = 0; i < MAX_BINS; i++) begin
        bin_total[i] = 0;
        bin_square_total[i] = '0;
      end
      below_total = 0;
      above_total = 0;
      edges_cfg = NE_RESET;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.found_bin = out_mon.found_bin;
        got.bin_sum = out_mon.bin_sum;
        got.bin_sum_squares = out_mon.bin_sum_squares;
        got.underflow_sum = out_mon.underflow_sum;
        got.overflow_sum = out_mon.overflow_sum;
        got.saturated = out_mon.saturated;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, expected none, got %p",
                   $time, got);
        end else begin
          want = expected_q.pop_front();
          bad = field_differs("found_bin", want.found_bin, got.found_bin)
              + field_differs("bin_sum", want.bin_sum, got.bin_sum)
              + field_differs("bin_sum_squares", want.bin_sum_squares, got.bin_sum_squares)
              + field_differs("underflow_sum", want.underflow_sum, got.underflow_sum)
              + field_differs("overflow_sum", want.overflow_sum, got.overflow_sum)
              + field_differs("saturated", want.saturated, got.saturated);
          if (bad != 0) mismatches++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.insert(expected_q.size(),
                          apply_item(action_e'(in_mon.action), in_mon.index,
                                     in_mon.value, in_mon.weight));
      end
      if (psel && penable && pwrite && pready && paddr == NUM_EDGES_ADDR) begin
        edges_cfg = pwdata[NE_W-1:0];
      end
    end
    pending_count_o = expected_q.size();
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import whb_pkg::*;

  localparam logic [CFG_AW-1:0] NUM_EDGES_ADDR = '0;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT_RESULT = 200;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  whb_in_if  in_ch ();
  whb_out_if out_ch ();

  int               mismatch_count;
  int               pending_count;
  int               items_sent = 0;
  int               results_seen = 0;
  bit               quiet = 1'b0;
  bit               sender_calm = 1'b0;
  int               edges_now = MAX_BINS + 1;
  logic [VAL_W-1:0] edge_mirror [0:MAX_BINS];

  weighted_variable_bin_histogram_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  whb_result_compare #(
    .NUM_EDGES_ADDR (NUM_EDGES_ADDR)
  ) result_compare (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(64'd12_000_000);
    $display("weighted_variable_bin_histogram_top: mismatch");
    $finish;
  end

  // The result side stalls in bursts and once holds off long enough to back up the input.
  initial begin : result_side
    int burst;
    int hold;
    int calm_left;
    bit calm;
    bit held;
    burst = 0;
    hold = 0;
    calm_left = 300;
    calm = 1'b0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) results_seen++;
      calm_left--;
      if (calm_left <= 0) begin
        calm = ($urandom_range(0, 2) == 0);
        calm_left = 300;
      end
      if (!held && results_seen == HOLD_AT_RESULT) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(action_e act, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] v,
                           logic [WGT_W-1:0] w);
    if (!quiet && !sender_calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.index <= idx;
    in_ch.value <= v;
    in_ch.weight <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (act == ACT_WRITE && idx <= MAX_BINS) edge_mirror[idx] = v;
    if (items_sent % 50 == 0) sender_calm = ($urandom_range(0, 2) == 0);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [NE_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= CFG_DW'(data);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    edges_now = (data < 2) ? 2 : (data > MAX_BINS + 1) ? MAX_BINS + 1 : int'(data);
  endtask

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return WGT_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Energies cluster on and around the edges in use so bin boundaries are hit often.
  function automatic logic [VAL_W-1:0] pick_energy();
    int j;
    logic [VAL_W-1:0] base;
    j = $urandom_range(0, edges_now - 1);
    base = edge_mirror[j];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      4: return base - 1;
      5: return base + 1;
      6: return base;
      default: begin
        if (j < edges_now - 1 && edge_mirror[j+1] > base) begin
          return base + ($urandom % (edge_mirror[j+1] - base));
        end
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_edge(int j);
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    lo = (j == 0) ? '0 : edge_mirror[j-1];
    hi = (j >= MAX_BINS) ? '1 : edge_mirror[j+1];
    if ($urandom_range(0, 6) == 0 || hi <= lo) return $urandom;
    return lo + ($urandom % (hi - lo));
  endfunction

  task automatic directed_items();
    logic [VAL_W-1:0] keep10;
    logic [VAL_W-1:0] keep20;
    keep10 = edge_mirror[10];
    keep20 = edge_mirror[20];
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_FILL, '0, '0, 32'h7FFF_FFFF);
    send_item(ACT_FILL, '1, '1, 32'h8000_0000);
    send_item(ACT_FILL, 7'd3, edge_mirror[0], 32'h0000_0001);
    send_item(ACT_FILL, 7'd3, edge_mirror[MAX_BINS] - 1, 32'hFFFF_FFFF);
    send_item(ACT_FILL, 7'd3, edge_mirror[MAX_BINS], 32'h0001_0000);
    send_item(ACT_FILL, 7'd3, edge_mirror[0] - 1, 32'hFFFF_0000);
    repeat (4) send_item(ACT_FILL, '0, edge_mirror[5], 32'h8000_0000);
    send_item(ACT_READ, 7'd5, '1, '1);
    send_item(ACT_READ, 7'd0, '0, '0);
    send_item(ACT_READ, 7'd63, '0, '0);
    send_item(ACT_READ, 7'd64, '0, '0);
    send_item(ACT_READ, 7'd127, '0, '0);
    // Writes past the last edge slot must leave the table alone.
    send_item(ACT_WRITE, 7'd65, '0, '0);
    send_item(ACT_WRITE, 7'd127, '1, '0);
    send_item(ACT_FILL, '0, '0, 32'h0000_0100);
    send_item(ACT_FILL, '0, '1, 32'h0000_0100);
    // Equal and descending edges.
    send_item(ACT_WRITE, 7'd10, edge_mirror[9], '0);
    send_item(ACT_FILL, '0, edge_mirror[9], 32'h0002_0000);
    send_item(ACT_WRITE, 7'd20, '0, '0);
    send_item(ACT_FILL, '0, edge_mirror[25], 32'h0003_0000);
    send_item(ACT_WRITE, 7'd20, keep20, '0);
    send_item(ACT_WRITE, 7'd10, keep10, '0);
    send_item(ACT_CLEAR, '1, '1, '1);
    send_item(ACT_READ, 7'd5, '0, '0);
  endtask

  task automatic random_items(int count);
    int pick;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] v;
    logic [WGT_W-1:0] w;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      idx = IDX_W'($urandom);
      v = $urandom;
      w = pick_weight();
      if (pick < 2) begin
        send_item(ACT_CLEAR, idx, v, w);
      end else if (pick < 14) begin
        if ($urandom_range(0, 9) == 0) begin
          idx = IDX_W'($urandom_range(MAX_BINS + 1, 127));
        end else begin
          idx = IDX_W'($urandom_range(0, MAX_BINS));
          v = pick_edge(int'(idx));
        end
        send_item(ACT_WRITE, idx, v, w);
      end else if (pick < 75) begin
        send_item(ACT_FILL, idx, pick_energy(), w);
      end else begin
        if ($urandom_range(0, 6) == 0) idx = IDX_W'($urandom_range(MAX_BINS, 127));
        else idx = IDX_W'($urandom_range(0, MAX_BINS - 1));
        send_item(ACT_READ, idx, v, w);
      end
    end
  endtask

  initial begin : stimulus
    logic [NE_W-1:0] settings [PHASES];
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_CLEAR;
    in_ch.index <= '0;
    in_ch.value <= '0;
    in_ch.weight <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    settings = '{7'd0, 7'd2, 7'd1, 7'd127, 7'd64, 7'd3, 7'd65, 7'd0, 7'd0, 7'd66};
    settings[7] = NE_W'($urandom_range(0, 127));
    settings[8] = NE_W'($urandom_range(2, MAX_BINS + 1));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_write(NUM_EDGES_ADDR, NE_RESET);
    // Every edge slot is written before the first fill.
    for (int i = 0; i <= MAX_BINS; i++) begin
      send_item(ACT_WRITE, IDX_W'(i),
                VAL_W'(32'h0100_0000 + i * 32'h0300_0000 + $urandom_range(0, 32'h00FF_FFFF)),
                pick_weight());
    end
    directed_items();
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      cfg_write(NUM_EDGES_ADDR, settings[p]);
      if (p == PHASES - 1) quiet = 1'b1;
      random_items(PHASE_ITEMS);
    end
    drain_results();
    repeat (2 * (MAX_BINS + 2)) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("weighted_variable_bin_histogram_top: match");
    end else begin
      $display("weighted_variable_bin_histogram_top: mismatch");
    end
    $finish;
  end

endmodule
